>>> sv/qph_pkg.sv
// Shared types, codes and defaults for the quadratic probe hash table.
package qph_pkg;

    // Default table geometry
    localparam int SLOT_COUNT_DEF  = 16;
    localparam int PROBE_LIMIT_DEF = 32;

    // Field widths
    localparam int OP_W     = 2;
    localparam int KEY_W    = 31;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;

    // Home slot reduction: key padded to whole digits, one digit per cycle
    localparam int DIGIT_W    = 4;
    localparam int MOD_DIGITS = (KEY_W + DIGIT_W - 1) / DIGIT_W;
    localparam int MOD_PAD_W  = MOD_DIGITS * DIGIT_W;
    localparam int DCNT_W     = (MOD_DIGITS > 1) ? $clog2(MOD_DIGITS) : 1;

    // Request codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Result codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd4;

    // One table entry as held in the slot memory
    typedef struct packed {
        logic               used;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } qph_entry_t;

    // Controller to datapath commands
    typedef struct packed {
        logic                load;
        logic                mod_step;
        logic                probe_start;
        logic                probe_next;
        logic                ins_write;
        logic                sweep_step;
        logic                res_load;
        logic [STATUS_W-1:0] res_status;
    } qph_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic slot_free;
        logic key_match;
        logic mod_last;
        logic sweep_last;
    } qph_stat_t;

endpackage

>>> sv/quadratic_probe_hash_table_unit.sv
// Top level of the quadratic probe hash table: sequencer and datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------
//  request  | start, busy          | op, key, value
//  result   | done (one cycle)     | status, found_value, slot
//
// Insert and lookup first reduce the key to its home slot one 4-bit digit at a time, then
// p probes (1 to PROBE_LIMIT) run one per cycle through the slot memory. Clear sweeps
// every slot; an unassigned op answers in the cycle after it is accepted. After reset
// the block sweeps the used bits of every slot with busy high. The result shows with
// busy already low, so a request may enter then; the receiver cannot stall.
module quadratic_probe_hash_table_unit
    import qph_pkg::*;
#(
    parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
    parameter int PROBE_LIMIT = PROBE_LIMIT_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [OP_W-1:0]           op,
    input  logic [KEY_W-1:0]          key,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      done,
    output logic [STATUS_W-1:0]       status,
    output logic signed [VALUE_W-1:0] found_value,
    output logic [SLOT_W-1:0]         slot
);

    qph_cmd_t  cmd;
    qph_stat_t stat;

    // Sequence each request transaction
    qph_ctrl #(
        .PROBE_LIMIT(PROBE_LIMIT)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Hold the table and compute probe positions
    qph_dp #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .key_in      (key),
        .value_in    (value),
        .stat        (stat),
        .status      (status),
        .found_value (found_value),
        .slot        (slot)
    );

endmodule

>>> sv/qph_ctrl.sv
// Request sequencer for the quadratic probe hash table.
module qph_ctrl
    import qph_pkg::*;
#(
    parameter int PROBE_LIMIT = PROBE_LIMIT_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [OP_W-1:0] op,
    input  qph_stat_t       stat,
    output qph_cmd_t        cmd,
    output logic            busy,
    output logic            done
);

    localparam int CNT_W = $clog2(PROBE_LIMIT + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PROBE_LIMIT);

    localparam logic [2:0] S_SWEEP = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_PROBE = 3'd4;
    localparam logic [2:0] S_CLEAR = 3'd5;

    logic [2:0]      state_reg, state_next;
    logic [OP_W-1:0] op_reg, op_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic            done_reg;
    logic            last_probe;

    assign last_probe = (cnt_reg == CNT_LAST);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    op_next  = op;
                    if (op == OP_CLEAR)
                    begin
                        state_next = S_CLEAR;
                    end
                    else if (op == OP_INSERT || op == OP_LOOKUP)
                    begin
                        state_next = S_MOD;
                    end
                    else
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_NOT_FOUND;
                    end
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (stat.mod_last)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.probe_start = 1'b1;
                cnt_next        = CNT_W'(1);
                state_next      = S_PROBE;
            end
            S_PROBE:
            begin
                if (op_reg == OP_INSERT)
                begin
                    if (stat.slot_free)
                    begin
                        cmd.ins_write  = 1'b1;
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_INSERTED;
                        state_next     = S_IDLE;
                    end
                    else if (last_probe)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_FULL;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        cmd.probe_next = 1'b1;
                        cnt_next       = cnt_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    if (stat.slot_free || (!stat.key_match && last_probe))
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_NOT_FOUND;
                        state_next     = S_IDLE;
                    end
                    else if (stat.key_match)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_FOUND;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        cmd.probe_next = 1'b1;
                        cnt_next       = cnt_reg + CNT_W'(1);
                    end
                end
            end
            S_CLEAR:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_CLEARED;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, request code and probe count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
            op_reg    <= OP_INSERT;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
            done_reg  <= cmd.res_load;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

>>> sv/qph_dp.sv
// Datapath: home slot reduction, probe stepping, slot memory and result registers.
module qph_dp
    import qph_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  qph_cmd_t                   cmd,
    input  logic [KEY_W-1:0]           key_in,
    input  logic signed [VALUE_W-1:0]  value_in,
    output qph_stat_t                  stat,
    output logic [STATUS_W-1:0]        status,
    output logic signed [VALUE_W-1:0]  found_value,
    output logic [SLOT_W-1:0]          slot
);

    localparam int PW = $clog2(SLOT_COUNT);
    localparam logic [PW:0]   N_W       = (PW + 1)'(SLOT_COUNT);
    localparam logic [PW-1:0] JUMP_INIT = PW'(1 % SLOT_COUNT);
    localparam logic [PW-1:0] ODD_INIT  = PW'(3 % SLOT_COUNT);
    localparam logic [PW-1:0] SLOT_LAST = PW'(SLOT_COUNT - 1);
    localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(MOD_DIGITS - 1);

    // Sum of two residues, folded back below the table size
    function automatic logic [PW-1:0] add_mod(input logic [PW-1:0] a, input logic [PW:0] b);
        logic [PW:0] s;
        begin
            s = {1'b0, a} + b;
            if (s >= N_W)
            begin
                s = s - N_W;
            end
            add_mod = s[PW-1:0];
        end
    endfunction

    logic [KEY_W-1:0]     key_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic [MOD_PAD_W-1:0] kshift_reg;
    logic [DCNT_W-1:0]    dcnt_reg;
    logic [PW-1:0]        rem_reg, rem_next;
    logic [PW-1:0]        pos_reg, jump_reg, odd_reg;
    logic [PW-1:0]        pos_next, jump_next, odd_next;
    logic [PW-1:0]        sweep_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [VALUE_W-1:0]   fval_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [PW+SLOT_W-1:0] pos_ext;

    qph_entry_t           mem [SLOT_COUNT];
    qph_entry_t           rd_data_reg;
    qph_entry_t           wr_data;
    logic                 wr_en;
    logic                 rd_en;
    logic [PW-1:0]        wr_addr;
    logic [PW-1:0]        rd_addr;

    // Reduce the key by one digit, one bit at a time
    always_comb
    begin
        logic [PW:0] t;
        rem_next = rem_reg;
        for (int i = 0; i < DIGIT_W; i++)
        begin
            t = {rem_next, kshift_reg[MOD_PAD_W-1-i]};
            if (t >= N_W)
            begin
                t = t - N_W;
            end
            rem_next = t[PW-1:0];
        end
    end

    // Advance probe position and the running square residues
    assign pos_next  = add_mod(pos_reg, {1'b0, jump_reg});
    assign jump_next = add_mod(jump_reg, {1'b0, odd_reg});
    assign odd_next  = add_mod(odd_reg, (PW + 1)'(2));

    // Latch the request, run the reduction and step the probe registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg    <= key_in;
            value_reg  <= value_in;
            kshift_reg <= MOD_PAD_W'(key_in);
            rem_reg    <= '0;
        end
        else if (cmd.mod_step)
        begin
            kshift_reg <= kshift_reg << DIGIT_W;
            rem_reg    <= rem_next;
        end
        if (cmd.probe_start)
        begin
            pos_reg  <= rem_reg;
            jump_reg <= JUMP_INIT;
            odd_reg  <= ODD_INIT;
        end
        else if (cmd.probe_next)
        begin
            pos_reg  <= pos_next;
            jump_reg <= jump_next;
            odd_reg  <= odd_next;
        end
    end

    // Count reduction digits and sweep addresses
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg  <= '0;
            sweep_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                dcnt_reg <= '0;
            end
            else if (cmd.mod_step)
            begin
                dcnt_reg <= dcnt_reg + DCNT_W'(1);
            end
            if (cmd.sweep_step)
            begin
                sweep_reg <= (sweep_reg == SLOT_LAST) ? '0 : sweep_reg + PW'(1);
            end
        end
    end

    // Slot memory port selection
    always_comb
    begin
        wr_en   = cmd.ins_write | cmd.sweep_step;
        wr_addr = cmd.sweep_step ? sweep_reg : pos_reg;
        wr_data = '0;
        if (!cmd.sweep_step)
        begin
            wr_data.used  = 1'b1;
            wr_data.key   = key_reg;
            wr_data.value = value_reg;
        end
        rd_en   = cmd.probe_start | cmd.probe_next;
        rd_addr = cmd.probe_start ? rem_reg : pos_next;
    end

    // Slot memory with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign stat.slot_free  = !rd_data_reg.used;
    assign stat.key_match  = (rd_data_reg.key == key_reg);
    assign stat.mod_last   = (dcnt_reg == DCNT_LAST);
    assign stat.sweep_last = (sweep_reg == SLOT_LAST);

    assign pos_ext = {{SLOT_W{1'b0}}, pos_reg};

    // Capture the result transaction
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            status_reg <= cmd.res_status;
            fval_reg   <= (cmd.res_status == ST_FOUND) ? rd_data_reg.value : '0;
            slot_reg   <= (cmd.res_status == ST_FOUND || cmd.res_status == ST_INSERTED)
                          ? pos_ext[SLOT_W-1:0] : '0;
        end
    end

    assign status      = status_reg;
    assign found_value = fval_reg;
    assign slot        = slot_reg;

endmodule

>>> dv/quadratic_probe_hash_table_unit_test.sv
// Self-checking testbench for the quadratic probe hash table unit.
module quadratic_probe_hash_table_unit_test;
    import qph_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Request code with no operation behind it
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam int ITEM_TARGET  = 1350;
    localparam int DRAIN_LIMIT  = 4000;
    localparam int SETTLE_TICKS = 60;

    // One answer as the block reports it
    typedef struct {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] found_value;
        logic [SLOT_W-1:0]         slot;
    } answer_t;

    // Mirror of the table contents and the answers still owed by the block
    class hash_table_tracker;
        logic [KEY_W-1:0]          keys [SLOT_COUNT_DEF];
        logic signed [VALUE_W-1:0] vals [SLOT_COUNT_DEF];
        bit                        used [SLOT_COUNT_DEF];
        answer_t                   owed [$];
        int unsigned               failures;

        function new();
            failures = 0;
            foreach (used[i])
            begin
                used[i] = 1'b0;
                keys[i] = '0;
                vals[i] = '0;
            end
        endfunction

        // Apply an accepted request to the mirror and queue the answer it earns
        function void note_request(logic [OP_W-1:0] req_op, logic [KEY_W-1:0] req_key,
                                   logic signed [VALUE_W-1:0] req_value);
            answer_t     ans;
            int unsigned pos;
            int unsigned probe;
            bit          stop;
            ans.status      = ST_NOT_FOUND;
            ans.found_value = '0;
            ans.slot        = '0;
            pos  = req_key % SLOT_COUNT_DEF;
            stop = 1'b0;
            case (req_op)
                OP_INSERT:
                begin
                    ans.status = ST_FULL;
                    for (probe = 1; probe <= PROBE_LIMIT_DEF && !stop; probe++)
                    begin
                        if (!used[pos])
                        begin
                            keys[pos]  = req_key;
                            vals[pos]  = req_value;
                            used[pos]  = 1'b1;
                            ans.status = ST_INSERTED;
                            ans.slot   = pos[SLOT_W-1:0];
                            stop       = 1'b1;
                        end
                        else
                            pos = (pos + (probe * probe) % SLOT_COUNT_DEF) % SLOT_COUNT_DEF;
                    end
                end
                OP_LOOKUP:
                begin
                    for (probe = 1; probe <= PROBE_LIMIT_DEF && !stop; probe++)
                    begin
                        // stop at an empty slot or the first matching key
                        if (!used[pos])
                            stop = 1'b1;
                        else if (keys[pos] == req_key)
                        begin
                            ans.status      = ST_FOUND;
                            ans.found_value = vals[pos];
                            ans.slot        = pos[SLOT_W-1:0];
                            stop            = 1'b1;
                        end
                        else
                            pos = (pos + (probe * probe) % SLOT_COUNT_DEF) % SLOT_COUNT_DEF;
                    end
                end
                OP_CLEAR:
                begin
                    // drop the used bits only; keys and values keep their contents
                    foreach (used[i])
                        used[i] = 1'b0;
                    ans.status = ST_CLEARED;
                end
                default: ;
            endcase
            owed.push_back(ans);
        endfunction

        // Compare a reported answer with the oldest one owed
        function void check_answer(logic [STATUS_W-1:0] got_status,
                                   logic signed [VALUE_W-1:0] got_value,
                                   logic [SLOT_W-1:0] got_slot);
            answer_t want;
            if (owed.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: unexpected answer status=%0d value=%0d slot=%0d",
                             $realtime, got_status, got_value, got_slot);
                return;
            end
            want = owed.pop_front();
            if (got_status !== want.status || got_value !== want.found_value ||
                got_slot !== want.slot)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $write("%0t: mismatch expected status=%0d value=%0d slot=%0d,",
                           $realtime, want.status, want.found_value, want.slot);
                    $display(" got status=%0d value=%0d slot=%0d",
                             got_status, got_value, got_slot);
                end
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [OP_W-1:0]           op;
    logic [KEY_W-1:0]          key;
    logic signed [VALUE_W-1:0] value;
    logic                      done;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] found_value;
    logic [SLOT_W-1:0]         slot;

    hash_table_tracker tracker = new();
    int unsigned       items_sent;

    quadratic_probe_hash_table_unit i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .key         (key),
        .value       (value),
        .done        (done),
        .status      (status),
        .found_value (found_value),
        .slot        (slot)
    );

    // Generate a 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Check every strobed answer at the edge that ends its cycle
    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check_answer(status, found_value, slot);
    end

    // Offer one request after a random gap and hold it until the block takes it
    task automatic issue_request(logic [OP_W-1:0] req_op, logic [KEY_W-1:0] req_key,
                                 logic signed [VALUE_W-1:0] req_value);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        op    <= req_op;
        key   <= req_key;
        value <= req_value;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        tracker.note_request(req_op, req_key, req_value);
        if (req_op != OP_SPARE)
            items_sent++;
    endtask

    // Run one table session: clear, then a burst of mostly inserts and lookups, with some spare ops and clears
    task automatic run_session();
        logic [KEY_W-1:0]          pool [6];
        logic [KEY_W-1:0]          pick;
        logic [OP_W-1:0]           pick_op;
        int                        length;
        int                        roll;
        bit                        crowded;
        crowded = ($urandom_range(0, 3) != 0);
        foreach (pool[i])
        begin
            pool[i] = KEY_W'($urandom());
            // pile most keys onto a few home slots to force long probe paths
            if (crowded)
                pool[i][3:0] = 4'($urandom_range(0, 2) * 5);
        end
        issue_request(OP_CLEAR, KEY_W'($urandom()), VALUE_W'($urandom()));
        length = $urandom_range(8, 40);
        for (int n = 0; n < length; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 46)
                pick_op = OP_INSERT;
            else if (roll < 92)
                pick_op = OP_LOOKUP;
            else if (roll < 96)
                pick_op = OP_SPARE;
            else
                pick_op = OP_CLEAR;
            if ($urandom_range(0, 3) != 0)
                pick = pool[$urandom_range(0, 5)];
            else
                pick = KEY_W'($urandom());
            issue_request(pick_op, pick, VALUE_W'($urandom()));
        end
    endtask

    // Hold reset, drive directed then random requests, drain and report
    initial
    begin
        int waited;
        clk        = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        op         = OP_INSERT;
        key        = '0;
        value      = '0;
        items_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, field extremes and duplicate keys
        issue_request(OP_LOOKUP, '0, '0);
        issue_request(OP_INSERT, '0, 32'sh8000_0000);
        issue_request(OP_INSERT, '1, 32'sh7FFF_FFFF);
        issue_request(OP_INSERT, '0, -32'sd1);
        issue_request(OP_LOOKUP, '0, '1);
        issue_request(OP_LOOKUP, '1, '0);
        issue_request(OP_LOOKUP, 31'd16, '0);
        issue_request(OP_SPARE, '1, '1);
        issue_request(OP_INSERT, 31'h5555_5555, 32'sh5555_5555);
        issue_request(OP_LOOKUP, 31'h2AAA_AAAA, 32'shAAAA_AAAA);

        // clear empties every slot before a lookup of an earlier key
        issue_request(OP_CLEAR, '1, '1);
        issue_request(OP_LOOKUP, '0, '0);

        // insert twelve keys sharing home slot zero, then look up an absent key on that path
        for (int k = 0; k < 12; k++)
            issue_request(OP_INSERT, KEY_W'(k * SLOT_COUNT_DEF), VALUE_W'(k + 100));
        issue_request(OP_LOOKUP, KEY_W'(99 * SLOT_COUNT_DEF), '0);

        // random sessions
        while (items_sent < ITEM_TARGET)
            run_session();

        start <= 1'b0;
        waited = 0;
        while (tracker.owed.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_TICKS) @(posedge clk);

        if (tracker.failures == 0 && tracker.owed.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Abort a hung run
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
sv/qph_pkg.sv
sv/qph_ctrl.sv
sv/qph_dp.sv
sv/quadratic_probe_hash_table_unit.sv
dv/quadratic_probe_hash_table_unit_test.sv
